// ===== rtl/core/tsfu_pkg.sv =====
// Shared types, codes and saturation helpers for the Taylor series function unit.
// Used by tsfu_mul, tsfu_div and taylor_series_function_unit_core.
package tsfu_pkg;

   localparam logic signed [63:0] ONE_Q40 = 64'sh0000_0100_0000_0000;
   localparam logic signed [63:0] MAX_Q40 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN_Q40 = 64'sh8000_0000_0000_0000;
   // 1.0 in the Q4.28 input format
   localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;

   // divider step counts: integer divisor and Q24.40 quotient
   localparam logic [6:0] INT_STEPS = 7'd65;
   localparam logic [6:0] Q40_STEPS = 7'd104;

   localparam logic [2:0] OP_SIN  = 3'd0;
   localparam logic [2:0] OP_COS  = 3'd1;
   localparam logic [2:0] OP_TAN  = 3'd2;
   localparam logic [2:0] OP_EXP  = 3'd3;
   localparam logic [2:0] OP_LN1P = 3'd4;
   localparam logic [2:0] OP_SINH = 3'd5;
   localparam logic [2:0] OP_COSH = 3'd6;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_DOMAIN = 2'd1;
   localparam logic [1:0] STAT_SLOW   = 2'd2;
   localparam logic [1:0] STAT_SAT    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQR,
      ST_SETUP,
      ST_MULH,
      ST_DIVT,
      ST_UPD,
      ST_POST,
      ST_FMUL,
      ST_TDIV,
      ST_LNINIT,
      ST_LNREC,
      ST_LNMUL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic               start;
      logic               q40;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } unit_req_type;

   typedef struct packed {
      logic               done;
      logic               ovf;
      logic signed [63:0] res;
   } unit_rsp_type;

   typedef struct packed {
      logic signed [63:0] val;
      logic               ovf;
   } sat_type;

   function automatic logic [63:0] mag_of(input logic signed [63:0] v);
      return v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
   endfunction

   function automatic sat_type from_mag(input logic [63:0] m, input logic neg);
      sat_type r;
      r.ovf = 1'b0;
      r.val = '0;
      if (neg) begin
         if (m > 64'h8000_0000_0000_0000) begin
            r.ovf = 1'b1;
            r.val = MIN_Q40;
         end else begin
            r.val = $signed(64'd0 - m);
         end
      end else if (m[63]) begin
         r.ovf = 1'b1;
         r.val = MAX_Q40;
      end else begin
         r.val = $signed(m);
      end
      return r;
   endfunction

   function automatic sat_type sat_add(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
      sat_type r;
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      r.ovf = s[64] != s[63];
      r.val = r.ovf ? (s[64] ? MIN_Q40 : MAX_Q40) : $signed(s[63:0]);
      return r;
   endfunction

   function automatic sat_type sat_sub(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
      sat_type r;
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      r.ovf = s[64] != s[63];
      r.val = r.ovf ? (s[64] ? MIN_Q40 : MAX_Q40) : $signed(s[63:0]);
      return r;
   endfunction

endpackage

// ===== rtl/core/tsfu_mul.sv =====
// Shared 64x64 signed multiplier: four 32x32 partial products accumulated in turn,
// Q24.40 rounding and saturation, or the plain rounded square for x*x. Uses tsfu_pkg.
module tsfu_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  tsfu_pkg::unit_req_type req,
   output tsfu_pkg::unit_rsp_type rsp
);

   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic         neg_ff, neg_in, q40_ff, q40_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;

   logic [31:0]  a_half, b_half;
   logic [127:0] addend;
   logic [63:0]  mag_q40;
   tsfu_pkg::sat_type fm;

   // partial product order: a0*b0, a0*b1, a1*b0, a1*b1
   assign a_half = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_half = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];

   always_comb begin
      case (sh_ff)
         2'd0:    addend = {64'd0, pp_ff};
         2'd1:    addend = {32'd0, pp_ff, 32'd0};
         default: addend = {pp_ff, 64'd0};
      endcase
   end

   always_comb begin
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      q40_in  = q40_ff;
      acc_in  = acc_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         ma_in   = tsfu_pkg::mag_of(req.a);
         mb_in   = tsfu_pkg::mag_of(req.b);
         neg_in  = req.a[63] ^ req.b[63];
         q40_in  = req.q40;
         acc_in  = req.q40 ? (128'd1 << 39) : (128'd1 << 15);
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         pp_in  = {32'd0, a_half} * {32'd0, b_half};
         sh_in  = {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0]};
         if (cnt_ff != 3'd0) begin
            acc_in = acc_ff + addend;
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      q40_ff <= q40_in;
      acc_ff <= acc_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
   end

   assign mag_q40 = (acc_ff[127:103] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_ff[103:40];
   assign fm      = tsfu_pkg::from_mag(mag_q40, neg_ff);

   assign rsp.done = done_ff;
   assign rsp.ovf  = q40_ff ? fm.ovf : 1'b0;
   assign rsp.res  = q40_ff ? fm.val : $signed(acc_ff[79:16]);

endmodule

// ===== rtl/core/tsfu_div.sv =====
// Shared restoring divider, one quotient bit per cycle: rounded division by an
// integer (65 steps) or Q24.40 by Q24.40 (104 steps). Uses tsfu_pkg.
module tsfu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tsfu_pkg::unit_req_type req,
   output tsfu_pkg::unit_rsp_type rsp
);

   logic [103:0] dv_ff, dv_in;
   logic [63:0]  rem_ff, rem_in, q_ff, q_in, den_ff, den_in;
   logic         neg_ff, neg_in, q40_ff, q40_in, big_ff, big_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;

   logic [63:0]  ma, mb;
   logic [64:0]  biased;
   logic [64:0]  r2, r2_sub;
   logic         ge;
   logic [63:0]  m;
   tsfu_pkg::sat_type fm;

   assign ma     = tsfu_pkg::mag_of(req.a);
   assign mb     = tsfu_pkg::mag_of(req.b);
   // integer mode rounds by adding half the divisor up front
   assign biased = {1'b0, ma} + {2'b0, mb[63:1]};

   assign r2     = {rem_ff, dv_ff[103]};
   assign r2_sub = r2 - {1'b0, den_ff};
   assign ge     = r2 >= {1'b0, den_ff};

   always_comb begin
      dv_in   = dv_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      q40_in  = q40_ff;
      big_in  = big_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dv_in   = req.q40 ? {ma, 40'd0} : {biased, 39'd0};
         rem_in  = '0;
         q_in    = '0;
         den_in  = mb;
         neg_in  = req.a[63] ^ req.b[63];
         q40_in  = req.q40;
         big_in  = 1'b0;
         cnt_in  = req.q40 ? tsfu_pkg::Q40_STEPS : tsfu_pkg::INT_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dv_in  = {dv_ff[102:0], 1'b0};
         rem_in = ge ? r2_sub[63:0] : r2[63:0];
         big_in = big_ff | (q_ff[63:62] != 2'b00);
         q_in   = {q_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dv_ff  <= dv_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      q40_ff <= q40_in;
      big_ff <= big_in;
   end

   always_comb begin
      if (!q40_ff) begin
         m = q_ff;
      end else if (big_ff) begin
         m = 64'hFFFF_FFFF_FFFF_FFFF;
      end else if (rem_ff >= den_ff - rem_ff) begin
         m = q_ff + 64'd1;
      end else begin
         m = q_ff;
      end
   end

   assign fm = tsfu_pkg::from_mag(m, neg_ff);

   assign rsp.done = done_ff;
   assign rsp.ovf  = fm.ovf;
   assign rsp.res  = fm.val;

endmodule

// ===== rtl/core/taylor_series_function_unit_core.sv =====
// Top level of the Taylor series function unit: sequencer, working registers,
// result register. Instantiates tsfu_mul and tsfu_div; uses tsfu_pkg.
//
// Computes sin, cos, tan, exp, ln(1+x), sinh or cosh (selected by req_tuser) of a Q4.28
// argument as a Horner-form truncated series and returns a saturated Q24.40 result with
// a status code. One item is in work at a time; req_tready is high only while idle, and a
// finished result waits in the output register while the next item is taken. Each series
// term runs the shared multiplier and the shared bit-serial divider, and most of an item's
// time is spent in the divider. Op 7, ln(1+x) with x <= -1 and tan at a zero cosine return
// 0 with the domain error status.
module taylor_series_function_unit_core #(
   parameter int SERIES_TERMS = 30,
   parameter int LOG_TERMS    = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] x
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] result
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int KMAX = (LOG_TERMS > SERIES_TERMS) ? LOG_TERMS : SERIES_TERMS;
   localparam int KW   = $clog2(KMAX + 1);
   localparam int DW   = 2 * KW + 2;

   tsfu_pkg::state_type state_ff, state_in;
   logic                go_ff, go_in;
   logic [2:0]          op_ff, op_in;
   logic signed [31:0]  xs_ff, xs_in;
   logic signed [63:0]  xq_ff, xq_in, x2_ff, x2_in, h_ff, h_in, t_ff, t_in;
   logic signed [63:0]  u_ff, u_in, c_ff, c_in, res_ff, res_in;
   logic [KW-1:0]       k_ff, k_in;
   logic                ovf_ff, ovf_in, pass_ff, pass_in;
   logic [1:0]          stat_ff, stat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_result_ff, rsp_result_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   tsfu_pkg::unit_req_type mul_req, div_req;
   tsfu_pkg::unit_rsp_type mul_rsp, div_rsp;

   logic                odd, alt, slot_free, req_xfer;
   logic [KW:0]         k2, k2n;
   logic [DW-1:0]       series_div;
   tsfu_pkg::sat_type   upd_sat, ln_sat;

   tsfu_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   tsfu_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign req_tready = state_ff == tsfu_pkg::ST_IDLE;
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign odd = (op_ff == tsfu_pkg::OP_SIN) || (op_ff == tsfu_pkg::OP_SINH) ||
                ((op_ff == tsfu_pkg::OP_TAN) && pass_ff);
   assign alt = (op_ff == tsfu_pkg::OP_SIN) || (op_ff == tsfu_pkg::OP_COS) ||
                (op_ff == tsfu_pkg::OP_TAN);

   // series divisor: 2k(2k+1) for odd series, (2k-1)2k for even
   assign k2         = {k_ff, 1'b0};
   assign k2n        = odd ? (k2 + 1'b1) : (k2 - 1'b1);
   assign series_div = DW'(k2) * DW'(k2n);

   assign upd_sat = alt ? tsfu_pkg::sat_sub(tsfu_pkg::ONE_Q40, t_ff)
                        : tsfu_pkg::sat_add(tsfu_pkg::ONE_Q40, t_ff);
   assign ln_sat  = tsfu_pkg::sat_sub(u_ff, mul_rsp.res);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsfu_pkg::ST_IDLE:   if (req_tvalid) state_in = tsfu_pkg::ST_SQR;
         tsfu_pkg::ST_SQR:    if (mul_rsp.done) state_in = tsfu_pkg::ST_SETUP;
         tsfu_pkg::ST_SETUP: begin
            unique case (op_ff) inside
               tsfu_pkg::OP_SIN, tsfu_pkg::OP_COS, tsfu_pkg::OP_TAN, tsfu_pkg::OP_EXP,
               tsfu_pkg::OP_SINH, tsfu_pkg::OP_COSH:
                  state_in = tsfu_pkg::ST_MULH;
               tsfu_pkg::OP_LN1P:
                  state_in = (xs_ff <= -tsfu_pkg::ONE_Q28) ? tsfu_pkg::ST_FIN
                                                           : tsfu_pkg::ST_LNINIT;
               default: state_in = tsfu_pkg::ST_FIN;
            endcase
         end
         tsfu_pkg::ST_MULH:   if (mul_rsp.done) state_in = tsfu_pkg::ST_DIVT;
         tsfu_pkg::ST_DIVT:   if (div_rsp.done) state_in = tsfu_pkg::ST_UPD;
         tsfu_pkg::ST_UPD:
            state_in = (k_ff == KW'(1)) ? tsfu_pkg::ST_POST : tsfu_pkg::ST_MULH;
         tsfu_pkg::ST_POST: begin
            unique case (op_ff) inside
               tsfu_pkg::OP_SIN, tsfu_pkg::OP_SINH: state_in = tsfu_pkg::ST_FMUL;
               tsfu_pkg::OP_TAN: begin
                  if (pass_ff)            state_in = tsfu_pkg::ST_FMUL;
                  else if (h_ff == '0)    state_in = tsfu_pkg::ST_FIN;
                  else                    state_in = tsfu_pkg::ST_MULH;
               end
               default: state_in = tsfu_pkg::ST_FIN;
            endcase
         end
         tsfu_pkg::ST_FMUL:
            if (mul_rsp.done) begin
               state_in = (op_ff == tsfu_pkg::OP_TAN) ? tsfu_pkg::ST_TDIV : tsfu_pkg::ST_FIN;
            end
         tsfu_pkg::ST_TDIV:   if (div_rsp.done) state_in = tsfu_pkg::ST_FIN;
         tsfu_pkg::ST_LNINIT: if (div_rsp.done) state_in = tsfu_pkg::ST_LNREC;
         tsfu_pkg::ST_LNREC:  if (div_rsp.done) state_in = tsfu_pkg::ST_LNMUL;
         tsfu_pkg::ST_LNMUL:
            if (mul_rsp.done) begin
               state_in = (k_ff == KW'(1)) ? tsfu_pkg::ST_FMUL : tsfu_pkg::ST_LNREC;
            end
         tsfu_pkg::ST_FIN:    if (slot_free) state_in = tsfu_pkg::ST_IDLE;
         default:             state_in = tsfu_pkg::ST_IDLE;
      endcase
   end

   // unit requests; go pulses on the first cycle of each state
   assign go_in = state_in != state_ff;

   always_comb begin
      mul_req.start = go_ff && ((state_ff == tsfu_pkg::ST_SQR) ||
                                (state_ff == tsfu_pkg::ST_MULH) ||
                                (state_ff == tsfu_pkg::ST_FMUL) ||
                                (state_ff == tsfu_pkg::ST_LNMUL));
      mul_req.q40   = state_ff != tsfu_pkg::ST_SQR;
      mul_req.a     = xq_ff;
      mul_req.b     = h_ff;
      if (state_ff == tsfu_pkg::ST_SQR) begin
         mul_req.a = 64'(xs_ff);
         mul_req.b = 64'(xs_ff);
      end else if ((state_ff == tsfu_pkg::ST_MULH) && (op_ff != tsfu_pkg::OP_EXP)) begin
         mul_req.a = x2_ff;
      end

      div_req.start = go_ff && ((state_ff == tsfu_pkg::ST_DIVT) ||
                                (state_ff == tsfu_pkg::ST_TDIV) ||
                                (state_ff == tsfu_pkg::ST_LNINIT) ||
                                (state_ff == tsfu_pkg::ST_LNREC));
      div_req.q40   = state_ff == tsfu_pkg::ST_TDIV;
      div_req.a     = tsfu_pkg::ONE_Q40;
      div_req.b     = 64'(k_ff);
      unique case (state_ff)
         tsfu_pkg::ST_DIVT: begin
            div_req.a = t_ff;
            div_req.b = (op_ff == tsfu_pkg::OP_EXP) ? 64'(k_ff) : 64'(series_div);
         end
         tsfu_pkg::ST_TDIV: begin
            div_req.a = res_ff;
            div_req.b = c_ff;
         end
         tsfu_pkg::ST_LNINIT: div_req.b = 64'(LOG_TERMS);
         default: ;
      endcase
   end

   // working registers and result register
   always_comb begin
      op_in         = op_ff;
      xs_in         = xs_ff;
      xq_in         = xq_ff;
      x2_in         = x2_ff;
      h_in          = h_ff;
      t_in          = t_ff;
      u_in          = u_ff;
      c_in          = c_ff;
      res_in        = res_ff;
      k_in          = k_ff;
      ovf_in        = ovf_ff;
      pass_in       = pass_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff) inside
         tsfu_pkg::ST_IDLE:
            if (req_xfer) begin
               op_in   = req_tuser;
               xs_in   = $signed(req_tdata);
               xq_in   = {{20{req_tdata[31]}}, req_tdata, 12'd0};
               ovf_in  = 1'b0;
               pass_in = 1'b0;
               stat_in = tsfu_pkg::STAT_OK;
               res_in  = '0;
            end
         tsfu_pkg::ST_SQR:
            if (mul_rsp.done) x2_in = mul_rsp.res;
         tsfu_pkg::ST_SETUP: begin
            h_in = tsfu_pkg::ONE_Q40;
            k_in = KW'(SERIES_TERMS - 1);
            if (op_ff == tsfu_pkg::OP_LN1P) begin
               if (xs_ff <= -tsfu_pkg::ONE_Q28)   stat_in = tsfu_pkg::STAT_DOMAIN;
               else if (xs_ff > tsfu_pkg::ONE_Q28) stat_in = tsfu_pkg::STAT_SLOW;
            end else if (op_ff > tsfu_pkg::OP_COSH) begin
               stat_in = tsfu_pkg::STAT_DOMAIN;
            end
         end
         tsfu_pkg::ST_MULH:
            if (mul_rsp.done) begin
               t_in   = mul_rsp.res;
               ovf_in = ovf_ff | mul_rsp.ovf;
            end
         tsfu_pkg::ST_DIVT:
            if (div_rsp.done) begin
               t_in   = div_rsp.res;
               ovf_in = ovf_ff | div_rsp.ovf;
            end
         tsfu_pkg::ST_UPD: begin
            h_in   = upd_sat.val;
            ovf_in = ovf_ff | upd_sat.ovf;
            k_in   = k_ff - KW'(1);
         end
         tsfu_pkg::ST_POST: begin
            res_in = h_ff;
            if ((op_ff == tsfu_pkg::OP_TAN) && !pass_ff) begin
               c_in = h_ff;
               if (h_ff == '0) begin
                  // cosine pole
                  stat_in = tsfu_pkg::STAT_DOMAIN;
                  ovf_in  = 1'b0;
               end else begin
                  pass_in = 1'b1;
                  h_in    = tsfu_pkg::ONE_Q40;
                  k_in    = KW'(SERIES_TERMS - 1);
               end
            end
         end
         tsfu_pkg::ST_FMUL, tsfu_pkg::ST_TDIV: begin
            if ((state_ff == tsfu_pkg::ST_FMUL) && mul_rsp.done) begin
               res_in = mul_rsp.res;
               ovf_in = ovf_ff | mul_rsp.ovf;
            end
            if ((state_ff == tsfu_pkg::ST_TDIV) && div_rsp.done) begin
               res_in = div_rsp.res;
               ovf_in = ovf_ff | div_rsp.ovf;
            end
         end
         tsfu_pkg::ST_LNINIT:
            if (div_rsp.done) begin
               h_in   = div_rsp.res;
               ovf_in = ovf_ff | div_rsp.ovf;
               k_in   = KW'(LOG_TERMS - 1);
            end
         tsfu_pkg::ST_LNREC:
            if (div_rsp.done) begin
               u_in   = div_rsp.res;
               ovf_in = ovf_ff | div_rsp.ovf;
            end
         tsfu_pkg::ST_LNMUL:
            if (mul_rsp.done) begin
               h_in   = ln_sat.val;
               ovf_in = ovf_ff | mul_rsp.ovf | ln_sat.ovf;
               k_in   = k_ff - KW'(1);
            end
         tsfu_pkg::ST_FIN:
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (stat_ff == tsfu_pkg::STAT_DOMAIN) begin
                  rsp_result_in = '0;
                  rsp_status_in = tsfu_pkg::STAT_DOMAIN;
               end else begin
                  rsp_result_in = res_ff;
                  rsp_status_in = ovf_ff ? tsfu_pkg::STAT_SAT : stat_ff;
               end
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsfu_pkg::ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      xs_ff         <= xs_in;
      xq_ff         <= xq_in;
      x2_ff         <= x2_in;
      h_ff          <= h_in;
      t_ff          <= t_in;
      u_ff          <= u_in;
      c_ff          <= c_in;
      res_ff        <= res_in;
      k_ff          <= k_in;
      ovf_ff        <= ovf_in;
      pass_ff       <= pass_in;
      stat_ff       <= stat_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_result_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_domain_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == tsfu_pkg::STAT_DOMAIN)) |-> (rsp_result_ff == '0))
      else $error("domain error result not zero");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == tsfu_pkg::ST_SQR))
      else $error("accepted transfer did not start the square");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.done && div_rsp.done))
      else $error("multiplier and divider finished together");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == tsfu_pkg::ST_UPD) || (state_ff == tsfu_pkg::ST_LNMUL)) |-> (k_ff != '0))
      else $error("term counter underflow");

endmodule

// ===== verif/tsfu_checker.sv =====
// Watches both channels of the Taylor series function unit, predicts each result and compares.
// Depends on tsfu_pkg for op and status codes and fixed-point constants.
module tsfu_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
   } func_result_type;

   func_result_type expected_q[$];
   logic            sat_seen;

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v[63] ? 64'd0 - v : v;
   endfunction

   function automatic logic signed [63:0] signed_clamp(input logic [63:0] m, input logic neg);
      if (neg) begin
         if (m > 64'h8000_0000_0000_0000) begin
            sat_seen = 1'b1;
            return tsfu_pkg::MIN_Q40;
         end
         return $signed(64'd0 - m);
      end
      if (m[63]) begin
         sat_seen = 1'b1;
         return tsfu_pkg::MAX_Q40;
      end
      return $signed(m);
   endfunction

   function automatic logic signed [63:0] add_q(input logic signed [63:0] a, b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_seen = 1'b1;
         return s[64] ? tsfu_pkg::MIN_Q40 : tsfu_pkg::MAX_Q40;
      end
      return $signed(s[63:0]);
   endfunction

   function automatic logic signed [63:0] sub_q(input logic signed [63:0] a, b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         sat_seen = 1'b1;
         return s[64] ? tsfu_pkg::MIN_Q40 : tsfu_pkg::MAX_Q40;
      end
      return $signed(s[63:0]);
   endfunction

   function automatic logic signed [63:0] mul_q(input logic signed [63:0] a, b);
      logic [127:0] p;
      logic [63:0]  m;
      p = {64'd0, abs64(a)} * {64'd0, abs64(b)} + (128'd1 << 39);
      m = (p >= (128'd1 << 103)) ? '1 : p[103:40];
      return signed_clamp(m, a[63] != b[63]);
   endfunction

   function automatic logic signed [63:0] div_by(input logic signed [63:0] a, input int unsigned d);
      logic [63:0] m;
      m = abs64(a);
      return signed_clamp((m + 64'(d / 2)) / 64'(d), a[63]);
   endfunction

   function automatic logic signed [63:0] quot_q(input logic signed [63:0] s, c);
      logic [127:0] num, qq, rr;
      logic [63:0]  mc, q;
      mc  = abs64(c);
      num = {64'd0, abs64(s)} << 40;
      qq  = num / {64'd0, mc};
      rr  = num % {64'd0, mc};
      if (qq >= (128'd1 << 63)) q = '1;
      else begin
         q = qq[63:0];
         if (rr[63:0] >= mc - rr[63:0]) q = q + 1;
      end
      return signed_clamp(q, s[63] != c[63]);
   endfunction

   // nested 1 +- x2/d (1 +- ...) for the sin/cos/tan/sinh/cosh family
   function automatic logic signed [63:0] even_series(input logic signed [63:0] x2,
                                                       input logic odd, input logic alt);
      logic signed [63:0] h, t;
      int unsigned d;
      h = tsfu_pkg::ONE_Q40;
      for (int k = 29; k >= 1; k--) begin
         d = odd ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
         t = div_by(mul_q(x2, h), d);
         h = alt ? sub_q(tsfu_pkg::ONE_Q40, t) : add_q(tsfu_pkg::ONE_Q40, t);
      end
      return h;
   endfunction

   function automatic func_result_type evaluate(input logic [2:0] op,
                                                input logic signed [31:0] x);
      func_result_type    r;
      logic signed [63:0] xq, x2, c, h;
      logic [63:0]        xm;
      xq = 64'(x) <<< 12;
      xm = abs64(64'(x));
      x2 = $signed((xm * xm + 64'd32768) >> 16);
      sat_seen = 1'b0;
      r.status = tsfu_pkg::STAT_OK;
      r.value = '0;
      case (op)
         tsfu_pkg::OP_SIN:  r.value = mul_q(xq, even_series(x2, 1'b1, 1'b1));
         tsfu_pkg::OP_COS:  r.value = even_series(x2, 1'b0, 1'b1);
         tsfu_pkg::OP_TAN: begin
            c = even_series(x2, 1'b0, 1'b1);
            if (c == 0) r.status = tsfu_pkg::STAT_DOMAIN;
            else r.value = quot_q(mul_q(xq, even_series(x2, 1'b1, 1'b1)), c);
         end
         tsfu_pkg::OP_EXP: begin
            h = tsfu_pkg::ONE_Q40;
            for (int k = 29; k >= 1; k--)
               h = add_q(tsfu_pkg::ONE_Q40, div_by(mul_q(xq, h), k));
            r.value = h;
         end
         tsfu_pkg::OP_LN1P: begin
            if (x <= -tsfu_pkg::ONE_Q28) r.status = tsfu_pkg::STAT_DOMAIN;
            else begin
               if (x > tsfu_pkg::ONE_Q28) r.status = tsfu_pkg::STAT_SLOW;
               h = div_by(tsfu_pkg::ONE_Q40, 100);
               for (int k = 99; k >= 1; k--)
                  h = sub_q(div_by(tsfu_pkg::ONE_Q40, k), mul_q(xq, h));
               r.value = mul_q(xq, h);
            end
         end
         tsfu_pkg::OP_SINH: r.value = mul_q(xq, even_series(x2, 1'b1, 1'b0));
         tsfu_pkg::OP_COSH: r.value = even_series(x2, 1'b0, 1'b0);
         default: r.status = tsfu_pkg::STAT_DOMAIN;
      endcase
      if (r.status == tsfu_pkg::STAT_DOMAIN) r.value = '0;
      else if (sat_seen) r.status = tsfu_pkg::STAT_SAT;
      return r;
   endfunction

   always @(posedge clock) begin
      func_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result transfer value=%h status=%0d",
                        $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata !== want.value) begin
                  $display("%0t: result expected %h actual %h", $time, want.value, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(evaluate(req_tuser, $signed(req_tdata)));
      end
      outstanding = expected_q.size();
   end

endmodule

// ===== verif/testbench.sv =====
// Stimulus and verdict for taylor_series_function_unit_core.
// Depends on tsfu_pkg and the tsfu_checker module.
module testbench;

   localparam int N_RANDOM  = 1430;
   localparam int IDLE_CAP  = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count;
   int          outstanding;
   logic        no_gaps;
   int          quiet_cycles;

   taylor_series_function_unit_core u_top (.*);

   tsfu_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver backpressure
   always @(negedge clock)
      rsp_tready <= no_gaps || ($urandom_range(99) >= 28);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_CAP) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic send_arg(input logic [2:0] op, input logic [31:0] x);
      while (!no_gaps && $urandom_range(99) < 28) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = x;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_arg();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
         2: return 32'($signed($urandom_range(32'h6000_0000)) - 32'sh3000_0000);
         default: return {{4{1'($urandom_range(1))}}, 28'($urandom())};
      endcase
   endfunction

   initial begin
      logic [31:0] edge_args[8];
      no_gaps    = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = tsfu_pkg::OP_SIN;
      edge_args = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, tsfu_pkg::ONE_Q28,
                    -tsfu_pkg::ONE_Q28, tsfu_pkg::ONE_Q28 + 1, -tsfu_pkg::ONE_Q28 + 1,
                    32'h1921_FB54};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 3; i++)
         for (int op = tsfu_pkg::OP_SIN; op <= tsfu_pkg::OP_COSH; op++)
            send_arg(3'(op), edge_args[i]);
      send_arg(tsfu_pkg::OP_TAN, edge_args[7]);
      send_arg(tsfu_pkg::OP_LN1P, edge_args[3]);
      send_arg(tsfu_pkg::OP_LN1P, edge_args[4]);
      send_arg(tsfu_pkg::OP_LN1P, edge_args[5]);
      send_arg(tsfu_pkg::OP_LN1P, edge_args[6]);
      send_arg(3'd7, 32'h1234_5678);

      for (int i = 0; i < N_RANDOM; i++) begin
         no_gaps = (i >= 500 && i < 700);
         send_arg(3'($urandom_range(7)), pick_arg());
      end
      req_tvalid = 1'b0;
      no_gaps = 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/tsfu_pkg.sv
rtl/core/tsfu_mul.sv
rtl/core/tsfu_div.sv
rtl/core/taylor_series_function_unit_core.sv
verif/tsfu_checker.sv
verif/testbench.sv
